// ----- hdl/rwdt_pkg.sv -----
// Shared types, constants and the id hash for the replay window device table.
`timescale 1ns / 1ps
`default_nettype none

package rwdt_pkg;

   // Table geometry (depth is a power of two, so the slot index wraps naturally)
   localparam int unsigned TABLE_DEPTH = 256;
   localparam int unsigned PROBE_LIMIT = 16;
   localparam int unsigned INDEX_W     = $clog2(TABLE_DEPTH);
   localparam int unsigned PROBE_W     = $clog2(PROBE_LIMIT + 1);

   // Field widths
   localparam int unsigned DEVICE_W = 64;
   localparam int unsigned SEQ_W    = 16;
   localparam int unsigned TIME_W   = 32;

   localparam int unsigned HASH_MULT = 131;
   localparam logic [TIME_W-1:0] STALE_RESET = TIME_W'(60000);

   typedef enum logic [1:0] {
      OUT_NEW    = 2'd0,
      OUT_KNOWN  = 2'd1,
      OUT_REPLAY = 2'd2,
      OUT_FULL   = 2'd3
   } outcome_type;

   typedef struct packed {
      logic        is_replay;
      outcome_type outcome;
   } result_type;

   // One table slot as stored in memory
   typedef struct packed {
      logic                valid;
      logic [DEVICE_W-1:0] device;
      logic [SEQ_W-1:0]    last_seq;
      logic [TIME_W-1:0]   last_time;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_CHECK,
      ST_RESULT
   } state_type;

   // h = h*131 + byte over the eight bytes, byte 7 first. Only the low index
   // bits of the hash are kept, and those depend on nothing above them.
   function automatic logic [INDEX_W-1:0] id_hash(input logic [DEVICE_W-1:0] id);
      logic [INDEX_W-1:0] h;
      h = '0;
      for (int b = 7; b >= 0; b--) begin
         h = INDEX_W'(h * INDEX_W'(HASH_MULT)) + INDEX_W'(id[8*b +: 8]);
      end
      return h;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/rwdt_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rwdt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- hdl/rwdt_ctrl.sv -----
// Probe sequencer: hashes the id, walks the table memory and writes back.
`timescale 1ns / 1ps
`default_nettype none

module rwdt_ctrl
   import rwdt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // request beat
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [DEVICE_W-1:0] req_device_id,
   input  wire logic [SEQ_W-1:0]    req_sequence_req,
   input  wire logic [TIME_W-1:0]   req_now_ms,
   // configuration
   input  wire logic [TIME_W-1:0]   stale_window,
   // finished result toward the output register
   output      logic                res_valid,
   input  wire logic                res_take,
   output      result_type          res,
   // table memory
   output      logic                mem_wr_en,
   output      logic [INDEX_W-1:0]  mem_wr_addr,
   output      logic [ENTRY_W-1:0]  mem_wr_data,
   output      logic [INDEX_W-1:0]  mem_rd_addr,
   input  wire logic [ENTRY_W-1:0]  mem_rd_data
);

   localparam logic [PROBE_W-1:0] PROBE_LAST = PROBE_W'(PROBE_LIMIT - 1);
   localparam logic [INDEX_W-1:0] INDEX_LAST = INDEX_W'(TABLE_DEPTH - 1);
   localparam logic [SEQ_W-1:0]   SEQ_HALF   = SEQ_W'(32768);

   state_type           state_ff, state_in;
   logic [INDEX_W-1:0]  addr_ff, addr_in;
   logic [PROBE_W-1:0]  probe_ff, probe_in;
   logic [DEVICE_W-1:0] dev_ff, dev_in;
   logic [SEQ_W-1:0]    seq_ff, seq_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   result_type          res_ff, res_in;

   entry_type           entry;
   logic [SEQ_W-1:0]    delta;
   logic [TIME_W-1:0]   age;
   logic                fresh;
   logic                hit;

   // Slot compare against the entry just read
   assign entry = entry_type'(mem_rd_data);
   assign delta = seq_ff - entry.last_seq;
   assign age   = now_ff - entry.last_time;
   assign fresh = ((delta != '0) && (delta < SEQ_HALF)) || (age > stale_window);
   assign hit   = (entry.device == dev_ff);

   assign res = res_ff;

   // State and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
         probe_ff <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         probe_ff <= probe_in;
      end
      dev_ff <= dev_in;
      seq_ff <= seq_in;
      now_ff <= now_in;
      res_ff <= res_in;
   end

   // Next state, memory control and outputs
   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      probe_in    = probe_ff;
      dev_in      = dev_ff;
      seq_in      = seq_ff;
      now_in      = now_ff;
      res_in      = res_ff;
      req_stall   = 1'b1;
      res_valid   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = addr_ff;
      mem_wr_data = '0;
      // next probe is read ahead while the current one is checked
      mem_rd_addr = (state_ff == ST_PROBE) ? addr_ff : addr_ff + INDEX_W'(1);

      unique case (state_ff)
         ST_CLEAR: begin
            // clearing pass after reset: writes each slot in turn, then goes idle
            mem_wr_en = 1'b1;
            addr_in   = addr_ff + INDEX_W'(1);
            if (addr_ff == INDEX_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               dev_in   = req_device_id;
               seq_in   = req_sequence_req;
               now_in   = req_now_ms;
               addr_in  = id_hash(req_device_id);
               probe_in = '0;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            mem_wr_data = {1'b1, dev_ff, seq_ff, now_ff};
            if (!entry.valid) begin
               mem_wr_en = 1'b1;
               res_in    = '{is_replay: 1'b0, outcome: OUT_NEW};
               state_in  = ST_RESULT;
            end else if (hit) begin
               if (fresh) begin
                  mem_wr_en = 1'b1;
                  res_in    = '{is_replay: 1'b0, outcome: OUT_KNOWN};
               end else begin
                  res_in    = '{is_replay: 1'b1, outcome: OUT_REPLAY};
               end
               state_in = ST_RESULT;
            end else if (probe_ff == PROBE_LAST) begin
               res_in   = '{is_replay: 1'b0, outcome: OUT_FULL};
               state_in = ST_RESULT;
            end else begin
               addr_in  = addr_ff + INDEX_W'(1);
               probe_in = probe_ff + PROBE_W'(1);
            end
         end
         ST_RESULT: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hdl/replay_window_device_table.sv -----
// Top level of the replay window device table: config register, output register, table.
`timescale 1ns / 1ps
`default_nettype none

// Anti-replay filter over a hashed device table. Each request beat carries a
// 64-bit device id, a 16-bit sequence number and the current millisecond time;
// each one yields exactly one response beat with the verdict. The id hashes
// (h*131 + byte) to a start slot and up to 16 slots are probed linearly, one
// per cycle through the single read port of the table memory. A request is
// accepted in the idle state and passes through the probe state, one check
// state per slot probed (1 to 16) and the result state before the next can be
// accepted. The result state is held while the output register still holds an
// earlier beat under rsp_stall; the verdict then waits until that beat leaves.
// After reset a clearing pass writes every one of the 256 slots, one a cycle,
// and requests stall until it ends; csr_wr_en writes to the stale window
// register are taken at any time. A finished response waits in the output
// register while the next request is taken.
module replay_window_device_table
   import rwdt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [DEVICE_W-1:0] req_device_id,
   input  wire logic [SEQ_W-1:0]    req_sequence_req,
   input  wire logic [TIME_W-1:0]   req_now_ms,
   // response channel
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic                rsp_is_replay,
   output      logic [1:0]          rsp_outcome,
   // configuration
   input  wire logic                csr_wr_en,
   input  wire logic [TIME_W-1:0]   csr_wr_data
);

   logic [TIME_W-1:0]  stale_ff, stale_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_res_ff, rsp_res_in;

   logic               res_valid;
   logic               res_take;
   result_type         res;

   logic               mem_wr_en;
   logic [INDEX_W-1:0] mem_wr_addr;
   logic [ENTRY_W-1:0] mem_wr_data;
   logic [INDEX_W-1:0] mem_rd_addr;
   logic [ENTRY_W-1:0] mem_rd_data;

   // Stale window register
   assign stale_in = csr_wr_en ? csr_wr_data : stale_ff;

   // Output register: loads when empty or when its beat leaves
   assign res_take     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = (res_valid && res_take) ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_res_in   = (res_valid && res_take) ? res : rsp_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stale_ff     <= STALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         stale_ff     <= stale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_is_replay = rsp_res_ff.is_replay;
   assign rsp_outcome   = rsp_res_ff.outcome;

   rwdt_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_device_id    (req_device_id),
      .req_sequence_req (req_sequence_req),
      .req_now_ms       (req_now_ms),
      .stale_window     (stale_ff),
      .res_valid        (res_valid),
      .res_take         (res_take),
      .res              (res),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data)
   );

   rwdt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire
